// ===== design/mmi_pkg.sv =====
package mmi_pkg;

  localparam int unsigned W = 61;
  localparam int unsigned IN_W = 64;
  localparam int unsigned OUT_TDATA_W = 64;

  // prime modulus 2^61-1
  localparam logic [W-1:0] MOD = {W{1'b1}};

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture reduced operand, init coefficients
    logic step;   // one binary-GCD step
    logic emit;   // move result into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic finish; // u==0, u==1 or v==1
  } sts_t;

endpackage

// ===== design/mmi_ctrl.sv =====
module mmi_ctrl
  import mmi_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd.load = (state_r == S_IDLE) && in_tvalid;
    cmd.step = (state_r == S_RUN) && !sts.finish;
    cmd.emit = (state_r == S_RUN) && sts.finish && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_RUN;
      end
      S_RUN: begin
        if (sts.finish && out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/mmi_dp.sv =====
module mmi_dp
  import mmi_pkg::*;
(
  input  logic                   clk,
  input  logic [IN_W-1:0]        value,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  output logic [W-1:0]           inverse
);

  // invariants: x1*a == u, x2*a == v (mod M)
  logic [W-1:0] u_r, v_r, x1_r, x2_r, res_r;
  logic [W-1:0] u_nxt, v_nxt, x1_nxt, x2_nxt;

  logic [W:0]   fold;
  logic [W-1:0] red;
  logic [W:0]   d_uv, d_vu, d_12, d_21;
  logic [W-1:0] m_12, m_21;
  logic [W-1:0] result;

  function automatic logic [W-1:0] half_mod(input logic [W-1:0] x);
    // 2^61 == 1, so halving mod M is a rotate
    half_mod = {x[0], x[W-1:1]};
  endfunction

  // fold the top bits back in, then one conditional subtract
  always_comb begin
    fold = {1'b0, value[W-1:0]} + {{(2*W+1-IN_W){1'b0}}, value[IN_W-1:W]};
    if (fold >= {1'b0, MOD}) red = W'(fold - {1'b0, MOD});
    else red = fold[W-1:0];
  end

  always_comb begin
    d_uv = {1'b0, u_r} - {1'b0, v_r};
    d_vu = {1'b0, v_r} - {1'b0, u_r};
    d_12 = {1'b0, x1_r} - {1'b0, x2_r};
    d_21 = {1'b0, x2_r} - {1'b0, x1_r};
    m_12 = d_12[W] ? d_12[W-1:0] + MOD : d_12[W-1:0];
    m_21 = d_21[W] ? d_21[W-1:0] + MOD : d_21[W-1:0];
  end

  always_comb begin
    u_nxt  = u_r;
    v_nxt  = v_r;
    x1_nxt = x1_r;
    x2_nxt = x2_r;
    if (cmd.load) begin
      u_nxt  = red;
      v_nxt  = MOD;
      x1_nxt = W'(1);
      x2_nxt = '0;
    end else if (cmd.step) begin
      if (!u_r[0]) begin
        u_nxt  = u_r >> 1;
        x1_nxt = half_mod(x1_r);
      end else if (!v_r[0]) begin
        v_nxt  = v_r >> 1;
        x2_nxt = half_mod(x2_r);
      end else if (!d_uv[W]) begin
        u_nxt  = d_uv[W:1];
        x1_nxt = half_mod(m_12);
      end else begin
        v_nxt  = d_vu[W:1];
        x2_nxt = half_mod(m_21);
      end
    end
  end

  always_comb begin
    sts.finish = (u_r == '0) || (u_r == W'(1)) || (v_r == W'(1));
    if (u_r == '0) result = '0;
    else if (u_r == W'(1)) result = x1_r;
    else result = x2_r;
  end

  always_ff @(posedge clk) begin
    u_r  <= u_nxt;
    v_r  <= v_nxt;
    x1_r <= x1_nxt;
    x2_r <= x2_nxt;
    if (cmd.emit) res_r <= result;
  end

  assign inverse = res_r;

endmodule

// ===== design/mersenne61_modular_inverse.sv =====
// The binary-GCD loop sets the time from input accept to out_tvalid
//   (one shift or subtract-and-shift per cycle on 61-bit operands).
// Throughput: one word at a time; in_tready returns once the result is
//   loaded into the output register, which waits until that register is free.
// Reset (rst_n, synchronous, active low) clears the controller and out_tvalid;
//   datapath registers are not reset.
module mersenne61_modular_inverse
  import mmi_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_W-1:0]        in_tdata,    // [63:0] value
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata    // [60:0] inverse, [63:61] zero
);

  // Method: binary extended Euclid on (u, v) = (value mod M, M), with
  // coefficient pair (x1, x2) kept in [0, M). Division by two of a
  // coefficient is a 61-bit rotate because 2^61 == 1 mod M.
  // Each cycle: halve an even operand, or subtract the smaller odd operand
  // from the larger and halve the (even) difference. Every step drops at
  // least one bit from u or v, so the loop ends at u==1 (result x1),
  // v==1 (result x2), or at once when u==0 (no inverse, 0).

  cmd_t         cmd;
  sts_t         sts;
  logic [W-1:0] inverse;

  mmi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // operand reduction happens in the accept cycle
  mmi_dp u_dp (
    .clk     (clk),
    .value   (in_tdata),
    .cmd     (cmd),
    .sts     (sts),
    .inverse (inverse)
  );

  assign out_tdata = {{(OUT_TDATA_W-W){1'b0}}, inverse};

endmodule

// ===== design/mmi_checker.sv =====
module mmi_checker
  import mmi_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_W-1:0]        in_tdata,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one word in flight: busy right after accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted a word while busy");

  // result is canonical: padding zero and never the modulus itself
  a_canon: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[63:61] == 3'b000 && out_tdata[60:0] != MOD)
    else $error("non-canonical result");

  // out_tvalid is cleared by reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid after reset");

endmodule

bind mersenne61_modular_inverse mmi_checker u_mmi_checker (.*);

// ===== tb/sv/mmi_inverse_checker.sv =====
// Scoreboard for the mod 2^61-1 inverse block: predicts on input accept,
// compares on output accept, in order.
module mmi_inverse_checker
  import mmi_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_W-1:0]        in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     mismatch_cnt,
  output int                     pending_cnt,
  output int                     checked_cnt,
  output int                     no_inverse_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [W-1:0] expected_inverse_q [$];

  int n_mismatch   = 0;
  int n_pending    = 0;
  int n_checked    = 0;
  int n_no_inverse = 0;

  assign mismatch_cnt   = n_mismatch;
  assign pending_cnt    = n_pending;
  assign checked_cnt    = n_checked;
  assign no_inverse_cnt = n_no_inverse;

  // 64-bit operand folded into 0..MOD-1 (2^61 == 1 mod MOD)
  function automatic logic [W-1:0] fold_mod_prime(input logic [IN_W-1:0] v);
    logic [W:0] s;
    s = v[W-1:0] + v[IN_W-1:W];
    if (s >= MOD) s = s - MOD;
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] mul_mod_prime(input logic [W-1:0] a,
                                                  input logic [W-1:0] b);
    logic [2*W-1:0] prod;
    logic [W:0]     s;
    prod = a * b;
    s    = prod[W-1:0] + prod[2*W-1:W];
    if (s >= MOD) s = s - MOD;
    if (s >= MOD) s = s - MOD;
    return s[W-1:0];
  endfunction

  // Fermat: x^(MOD-2); a zero residue stays zero, which is the no-inverse answer
  function automatic logic [W-1:0] inverse_mod_prime(input logic [IN_W-1:0] v);
    logic [W-1:0] base;
    logic [W-1:0] acc;
    logic [W-1:0] expo;
    base = fold_mod_prime(v);
    acc  = 1;
    expo = MOD - 2;
    for (int i = W - 1; i >= 0; i--) begin
      acc = mul_mod_prime(acc, acc);
      if (expo[i]) acc = mul_mod_prime(acc, base);
    end
    return acc;
  endfunction

  always @(posedge clk) begin : compare_results
    logic [W-1:0]           want;
    logic [OUT_TDATA_W-1:0] want_word;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_inverse_q.push_back(inverse_mod_prime(in_tdata));
      end
      if (out_tvalid && out_tready) begin
        if (expected_inverse_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: unexpected out word %h at %0t", out_tdata, $realtime);
        end else begin
          want      = expected_inverse_q.pop_front();
          want_word = OUT_TDATA_W'(want);  // filler bits above the field are zero
          n_checked++;
          if (want == '0) n_no_inverse++;
          if (out_tdata !== want_word) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("mismatch: inverse expected %h got %h at %0t",
                       want_word, out_tdata, $realtime);
          end
        end
      end
      n_pending <= expected_inverse_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_mersenne61_modular_inverse.sv =====
// Top of the inverse testbench: clock, reset, stimulus, output back-pressure
// and verdict. All prediction and comparison lives in mmi_inverse_checker.
module tb_mersenne61_modular_inverse;
  timeunit 1ns;
  timeprecision 1ps;
  import mmi_pkg::*;

  localparam int RANDOM_WORDS = 1250;
  localparam int HOLD_CYCLES  = 400;   // long output hold-off, fills the block
  localparam int DRAIN_CYCLES = 130;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_W-1:0]        in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int mismatch_cnt;
  int pending_cnt;
  int checked_cnt;
  int no_inverse_cnt;
  int words_sent = 0;
  int long_holds = 0;

  // Operands aimed at the corners: zero, one, multiples of the prime, values
  // just above it (they fold back to small residues), all-ones and bit patterns.
  logic [IN_W-1:0] corner_values [0:19] = '{
    64'h0000_0000_0000_0000, 64'h0000_0000_0000_0001,
    64'h0000_0000_0000_0002, 64'h0000_0000_0000_0003,
    64'h1FFF_FFFF_FFFF_FFFE, 64'h1FFF_FFFF_FFFF_FFFF,  // prime-1, prime
    64'h2000_0000_0000_0000, 64'h2000_0000_0000_0001,  // prime+1, prime+2
    64'h3FFF_FFFF_FFFF_FFFE, 64'h3FFF_FFFF_FFFF_FFFF,  // 2*prime, 2*prime+1
    64'h5FFF_FFFF_FFFF_FFFD, 64'hDFFF_FFFF_FFFF_FFF9,  // 3*prime, 7*prime
    64'hFFFF_FFFF_FFFF_FFF8, 64'hFFFF_FFFF_FFFF_FFFF,  // 8*prime, all ones
    64'h8000_0000_0000_0000, 64'h1000_0000_0000_0000,
    64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
    64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000
  };

  mersenne61_modular_inverse i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // [63:0] value
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)     // [60:0] inverse, [63:61] zero
  );

  mmi_inverse_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_cnt   (mismatch_cnt),
    .pending_cnt    (pending_cnt),
    .checked_cnt    (checked_cnt),
    .no_inverse_cnt (no_inverse_cnt)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one word from the next falling edge; hold it until a rising edge
  // sees in_tready. Back-to-back calls keep in_tvalid high without a dip.
  task automatic offer_word(input logic [IN_W-1:0] v);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // Idle cycles on the input; data keeps toggling so nothing leaks through
  task automatic idle_input(input int n);
    repeat (n) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata  <= {$urandom, $urandom};
    end
  endtask

  // Random operand: mostly full-range or reduced values, plus small numbers,
  // values near the prime, exact and near multiples of it, and power-of-two shapes.
  function automatic logic [IN_W-1:0] pick_operand();
    logic [IN_W-1:0] v;
    logic [IN_W-1:0] prime64;
    int              r;
    prime64 = IN_W'(MOD);
    r = $urandom_range(0, 99);
    if (r < 40) begin
      v = {$urandom, $urandom};
    end else if (r < 60) begin
      v = {$urandom, $urandom} & prime64;
    end else if (r < 70) begin
      v = IN_W'($urandom_range(0, 1023));
    end else if (r < 78) begin
      v = prime64 - IN_W'($urandom_range(0, 1023));
    end else if (r < 86) begin
      // k*prime + {0..3}; offset 0 gives the no-inverse case
      v = IN_W'($urandom_range(0, 8)) * prime64 + IN_W'($urandom_range(0, 3));
    end else if (r < 93) begin
      v = (64'd1 << $urandom_range(0, 63)) + IN_W'($urandom_range(0, 2)) - 64'd1;
    end else begin
      // random top bits with a small residue underneath
      v = {3'($urandom_range(0, 7)), 61'($urandom_range(0, 255))};
    end
    return v;
  endfunction

  // Output side: modes of random length (always ready, coin flip, sparse,
  // periodic) plus two long hold-offs while the sender keeps offering words.
  initial begin : output_backpressure
    int mode;
    int span;
    int cycle_no;
    int next_hold_at;
    cycle_no     = 0;
    next_hold_at = 1500;
    @(posedge rst_n);
    forever begin
      if (long_holds < 2 && cycle_no >= next_hold_at) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        cycle_no     += HOLD_CYCLES;
        next_hold_at  = 60000;
        long_holds++;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 300);
        repeat (span) begin
          @(negedge clk);
          cycle_no++;
          case (mode)
            0: begin
              out_tready <= 1'b1;
            end
            1: begin
              out_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
              out_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
              out_tready <= ((cycle_no % 7) < 3);
            end
          endcase
        end
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    int burst_len;
    int gap_pick;
    int sent_random;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed corners, back to back
    foreach (corner_values[i]) offer_word(corner_values[i]);

    // random words in bursts; gaps from none to longer than one computation,
    // so the input restarts at every phase of the block's loop
    sent_random = 0;
    while (sent_random < RANDOM_WORDS) begin
      burst_len = $urandom_range(1, 12);
      for (int k = 0; k < burst_len && sent_random < RANDOM_WORDS; k++) begin
        offer_word(pick_operand());
        sent_random++;
      end
      gap_pick = $urandom_range(0, 9);
      if (gap_pick >= 9)      idle_input($urandom_range(41, 140));
      else if (gap_pick >= 8) idle_input($urandom_range(5, 40));
      else if (gap_pick >= 4) idle_input($urandom_range(1, 4));
    end
    idle_input(1);

    while (pending_cnt != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d words offered and %0d results checked, %0d of them with no inverse",
             words_sent, checked_cnt, no_inverse_cnt);
    $display("corner operands, random bursts and gaps, %0d long output hold-offs",
             long_holds);
    if (mismatch_cnt == 0) begin
      $display("[mersenne61_modular_inverse] OK");
    end else begin
      $display("[mersenne61_modular_inverse] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #30ms;
    $display("timeout with %0d results outstanding", pending_cnt);
    $display("[mersenne61_modular_inverse] ERROR");
    $finish;
  end

endmodule
